// File: sv/fsp_pkg.sv
// Shared types, constants and per-stage step functions of the sphere lattice generator.
`default_nettype none
package fsp_pkg;

    // Lattice sizing.
    localparam int unsigned EXTRA_POINTS = 100;
    localparam int unsigned MAX_TARGETS  = 4095;

    // Golden angle as a 16-bit fraction of a turn.
    localparam logic [14:0] GOLDEN_STEP = 15'd25032;

    // Result widths of the two digit recurrences and stage count of the sine unit.
    localparam int DIV_BITS  = 18;
    localparam int SQRT_BITS = 17;
    localparam int TRIG_STAGES = 8;

    // Odd polynomial coefficients of the quarter-wave sine, Q30.
    localparam logic [31:0] POLY_C9 = 32'd172272;
    localparam logic [31:0] POLY_HORNER [4] = '{32'd5026995, 32'd85569306,
                                                32'd693598668, 32'd1686629713};

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TARGET_COUNT  = 3'd0,
        CFG_SPHERE_RADIUS = 3'd1,
        CFG_CENTER_X      = 3'd2,
        CFG_CENTER_Y      = 3'd3,
        CFG_CENTER_Z      = 3'd4
    } t_cfg_idx;

    // Working set of one point as it travels down the pipeline.
    typedef struct packed {
        logic               inr;
        logic [29:0]        num;
        logic [12:0]        drem;
        logic [17:0]        quo;
        logic signed [17:0] y;
        logic [32:0]        srem;
        logic [16:0]        root;
        logic [15:0]        ang;
        logic               negs;
        logic               negc;
        logic [16:0]        xs;
        logic [16:0]        xc;
        logic [30:0]        x2s;
        logic [30:0]        x2c;
        logic [31:0]        ps;
        logic [31:0]        pc;
        logic [32:0]        sps;
        logic [32:0]        spc;
        logic [16:0]        sinm;
        logic [16:0]        cosm;
    } t_pt;

    // One restoring division step: brings in numerator bit b.
    function automatic t_pt div_step(input t_pt p, input logic [12:0] d, input int b);
        t_pt         q;
        logic [13:0] t;
        q = p;
        t = {p.drem, p.num[b]};
        if (t >= {1'b0, d}) begin
            q.drem   = 13'(t - {1'b0, d});
            q.quo[b] = 1'b1;
        end else begin
            q.drem = t[12:0];
        end
        return q;
    endfunction

    // One square-root step: decides root bit b.
    function automatic t_pt sqrt_step(input t_pt p, input int b);
        t_pt         q;
        logic [34:0] test;
        q = p;
        test = (35'(p.root) << (b + 1)) + (35'd1 << (2 * b));
        if (35'(p.srem) >= test) begin
            q.srem = 33'(35'(p.srem) - test);
            q.root = p.root | (17'd1 << b);
        end
        return q;
    endfunction

    // Quarter-wave argument for an angle, with the half-turn sign.
    function automatic logic [15:0] quarter_arg(input logic [15:0] a);
        logic [14:0] f;
        logic [14:0] u;
        f = {1'b0, a[13:0]};
        u = a[14] ? 15'(15'd16384 - f) : f;
        return {a[15], u};
    endfunction

    // One Horner step of the polynomial.
    function automatic logic [31:0] horner(input logic [30:0] x2, input logic [31:0] p,
                                           input logic [31:0] c);
        logic [62:0] m;
        m = 63'(x2) * 63'(p);
        return c - 32'(m >> 30);
    endfunction

    // Round a Q30 sine to Q16 and clamp it to one.
    function automatic logic [16:0] sin_round(input logic [32:0] s);
        logic [33:0] r;
        r = (34'(s) + 34'd8192) >> 14;
        return (r > 34'd65536) ? 17'd65536 : r[16:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/fsp_div.sv
// Entry stage and bit-per-stage divider giving the polar height quotient.
`default_nettype none
module fsp_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [12:0]   i_point_index,
    input  wire logic [12:0]   i_lat_n,
    input  wire logic [12:0]   i_div_d,
    output      logic          o_valid,
    output      fsp_pkg::t_pt  o_pt
);
    localparam int NST = fsp_pkg::DIV_BITS + 1;

    logic         r_v  [NST];
    fsp_pkg::t_pt r_pt [NST];
    fsp_pkg::t_pt n_pt [NST];
    logic [15:0]  w_ang;

    // Entry: numerator with half-divisor rounding, range flag and angle.
    assign w_ang = 16'(i_point_index) * 16'(fsp_pkg::GOLDEN_STEP);
    always_comb begin
        n_pt[0]      = '0;
        n_pt[0].inr  = i_point_index < i_lat_n;
        n_pt[0].num  = {i_point_index, 17'b0} + 30'(i_div_d >> 1);
        n_pt[0].drem = 13'(n_pt[0].num[29:18]);
        n_pt[0].ang  = w_ang;
    end

    // Each stage settles one quotient bit, most significant first.
    for (genvar k = 0; k < fsp_pkg::DIV_BITS; k++) begin : g_st
        assign n_pt[k + 1] = fsp_pkg::div_step(r_pt[k], i_div_d, fsp_pkg::DIV_BITS - 1 - k);
    end

    // Stage registers advance together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < NST; j++) r_v[j] <= r_v[j - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NST; j++) r_pt[j] <= n_pt[j];
        end
    end

    assign o_valid = r_v[NST - 1];
    assign o_pt    = r_pt[NST - 1];
endmodule
`default_nettype wire

// File: sv/fsp_sqrt.sv
// Height and ring radius: one square-root bit per stage.
`default_nettype none
module fsp_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire fsp_pkg::t_pt  i_pt,
    output      logic          o_valid,
    output      fsp_pkg::t_pt  o_pt
);
    localparam int NST = fsp_pkg::SQRT_BITS + 1;

    logic         r_v  [NST];
    fsp_pkg::t_pt r_pt [NST];
    fsp_pkg::t_pt n_pt [NST];
    logic [35:0]  w_prod;

    // One minus y squared equals q times (2 - q) in these units.
    assign w_prod = 36'(i_pt.quo) * 36'(18'(18'd131072 - i_pt.quo));
    always_comb begin
        n_pt[0]      = i_pt;
        n_pt[0].y    = 18'sd65536 - $signed(i_pt.quo);
        n_pt[0].srem = w_prod[32:0];
        n_pt[0].root = '0;
    end

    for (genvar k = 0; k < fsp_pkg::SQRT_BITS; k++) begin : g_st
        assign n_pt[k + 1] = fsp_pkg::sqrt_step(r_pt[k], fsp_pkg::SQRT_BITS - 1 - k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < NST; j++) r_v[j] <= r_v[j - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NST; j++) r_pt[j] <= n_pt[j];
        end
    end

    assign o_valid = r_v[NST - 1];
    assign o_pt    = r_pt[NST - 1];
endmodule
`default_nettype wire

// File: sv/fsp_trig.sv
// Sine and cosine of the lattice angle by a Horner polynomial, one product per stage.
`default_nettype none
module fsp_trig (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire fsp_pkg::t_pt  i_pt,
    output      logic          o_valid,
    output      fsp_pkg::t_pt  o_pt
);
    localparam int NST = fsp_pkg::TRIG_STAGES;

    logic         r_v  [NST];
    fsp_pkg::t_pt r_pt [NST];
    fsp_pkg::t_pt n_pt [NST];
    logic [15:0]  w_qs;
    logic [15:0]  w_qc;
    logic [33:0]  w_sqs;
    logic [33:0]  w_sqc;
    logic [48:0]  w_ms;
    logic [48:0]  w_mc;

    // Fold both angles into the first quadrant.
    assign w_qs = fsp_pkg::quarter_arg(i_pt.ang);
    assign w_qc = fsp_pkg::quarter_arg(16'(i_pt.ang + 16'd16384));
    always_comb begin
        n_pt[0]      = i_pt;
        n_pt[0].negs = w_qs[15];
        n_pt[0].negc = w_qc[15];
        n_pt[0].xs   = {w_qs[14:0], 2'b00};
        n_pt[0].xc   = {w_qc[14:0], 2'b00};
    end

    // Square of the argument, seeded with the top coefficient.
    assign w_sqs = 34'(r_pt[0].xs) * 34'(r_pt[0].xs);
    assign w_sqc = 34'(r_pt[0].xc) * 34'(r_pt[0].xc);
    always_comb begin
        n_pt[1]     = r_pt[0];
        n_pt[1].x2s = 31'(w_sqs >> 2);
        n_pt[1].x2c = 31'(w_sqc >> 2);
        n_pt[1].ps  = fsp_pkg::POLY_C9;
        n_pt[1].pc  = fsp_pkg::POLY_C9;
    end

    // Four Horner steps.
    for (genvar k = 0; k < 4; k++) begin : g_hn
        always_comb begin
            n_pt[k + 2]    = r_pt[k + 1];
            n_pt[k + 2].ps = fsp_pkg::horner(r_pt[k + 1].x2s, r_pt[k + 1].ps,
                                             fsp_pkg::POLY_HORNER[k]);
            n_pt[k + 2].pc = fsp_pkg::horner(r_pt[k + 1].x2c, r_pt[k + 1].pc,
                                             fsp_pkg::POLY_HORNER[k]);
        end
    end

    // Final odd factor, then rounding to Q16.
    assign w_ms = 49'(r_pt[5].xs) * 49'(r_pt[5].ps);
    assign w_mc = 49'(r_pt[5].xc) * 49'(r_pt[5].pc);
    always_comb begin
        n_pt[6]     = r_pt[5];
        n_pt[6].sps = w_ms[48:16];
        n_pt[6].spc = w_mc[48:16];
        n_pt[7]      = r_pt[6];
        n_pt[7].sinm = fsp_pkg::sin_round(r_pt[6].sps);
        n_pt[7].cosm = fsp_pkg::sin_round(r_pt[6].spc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < NST; j++) r_v[j] <= r_v[j - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NST; j++) r_pt[j] <= n_pt[j];
        end
    end

    assign o_valid = r_v[NST - 1];
    assign o_pt    = r_pt[NST - 1];
endmodule
`default_nettype wire

// File: sv/fsp_out.sv
// Scaling by the radius, rounding, centre offset and saturation; last stage is the output register.
`default_nettype none
module fsp_out (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire fsp_pkg::t_pt       i_pt,
    input  wire logic [23:0]        i_radius,
    input  wire logic signed [31:0] i_cx,
    input  wire logic signed [31:0] i_cy,
    input  wire logic signed [31:0] i_cz,
    output      logic               o_valid,
    output      logic signed [31:0] o_pos_x,
    output      logic signed [31:0] o_pos_y,
    output      logic signed [31:0] o_pos_z,
    output      logic               o_index_valid
);
    logic               r_v0;
    logic               r_v1;
    logic               r_v2;
    logic               r_inr0;
    logic               r_inr1;
    logic [2:0]         r_neg0;
    logic [2:0]         r_neg1;
    logic [32:0]        r_mx;
    logic [32:0]        r_mz;
    logic [40:0]        r_my;
    logic [25:0]        r_ax;
    logic [25:0]        r_ay;
    logic [25:0]        r_az;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;
    logic               r_iv;
    logic [16:0]        w_ym;
    logic [33:0]        w_mx;
    logic [33:0]        w_mz;
    logic [56:0]        w_px;
    logic [56:0]        w_pz;
    logic [56:0]        w_py;

    // Saturating signed sum of a rounded magnitude and a centre coordinate.
    function automatic logic signed [31:0] place(input logic neg, input logic [25:0] m,
                                                 input logic signed [31:0] c);
        logic signed [33:0] v;
        logic signed [33:0] s;
        v = neg ? -$signed({8'b0, m}) : $signed({8'b0, m});
        s = v + 34'(c);
        if (s > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (s < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // First products: trig times ring radius, height times sphere radius.
    assign w_ym = i_pt.y[17] ? 17'(-i_pt.y) : 17'(i_pt.y);
    assign w_mx = 34'(i_pt.cosm) * 34'(i_pt.root);
    assign w_mz = 34'(i_pt.sinm) * 34'(i_pt.root);

    // Second products and rounding half away from zero.
    assign w_px = 57'(r_mx) * 57'(i_radius);
    assign w_pz = 57'(r_mz) * 57'(i_radius);
    assign w_py = 57'(r_my);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inr0 <= i_pt.inr;
            r_neg0 <= {i_pt.negs, i_pt.y[17], i_pt.negc};
            r_mx   <= w_mx[32:0];
            r_mz   <= w_mz[32:0];
            r_my   <= 41'(w_ym) * 41'(i_radius);
            r_inr1 <= r_inr0;
            r_neg1 <= r_neg0;
            r_ax   <= 26'((w_px + 57'h80000000) >> 32);
            r_az   <= 26'((w_pz + 57'h80000000) >> 32);
            r_ay   <= 26'((w_py + 57'h8000) >> 16);
            r_iv   <= r_inr1;
            r_px   <= r_inr1 ? place(r_neg1[0], r_ax, i_cx) : '0;
            r_py   <= r_inr1 ? place(r_neg1[1], r_ay, i_cy) : '0;
            r_pz   <= r_inr1 ? place(r_neg1[2], r_az, i_cz) : '0;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    assign o_valid       = r_v2;
    assign o_pos_x       = r_px;
    assign o_pos_y       = r_py;
    assign o_pos_z       = r_pz;
    assign o_index_valid = r_iv;
endmodule
`default_nettype wire

// File: sv/fibonacci_sphere_points.sv
// Top level of the Fibonacci sphere lattice point generator.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------
//  in      | i_valid | o_stall | i_point_index
//  out     | o_valid | i_stall | o_pos_x, o_pos_y, o_pos_z, o_index_valid
//  config  | i_cfg_we| (none)  | i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle while the pipeline is not held, and passes 48 register
// stages: divider entry plus 18 quotient stages, root entry plus 17 square-root stages,
// 8 sine stages and 3 output stages, the last of which is the output register.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
// The whole pipeline advances as one; it holds only while a finished result is stalled,
// and then o_stall is raised so nothing is lost or repeated.
`default_nettype none
module fibonacci_sphere_points (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_stall,
    input  wire logic [12:0]        i_point_index,
    output      logic               o_valid,
    input  wire logic               i_stall,
    output      logic signed [31:0] o_pos_x,
    output      logic signed [31:0] o_pos_y,
    output      logic signed [31:0] o_pos_z,
    output      logic               o_index_valid,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    logic [11:0]        r_tc;
    logic [23:0]        r_radius;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic signed [31:0] r_cz;
    logic               w_adv;
    logic [11:0]        w_tc;
    logic [12:0]        w_lat_n;
    logic [12:0]        w_div_d;
    logic               w_v_div;
    logic               w_v_sqrt;
    logic               w_v_trig;
    fsp_pkg::t_pt       w_pt_div;
    fsp_pkg::t_pt       w_pt_sqrt;
    fsp_pkg::t_pt       w_pt_trig;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc     <= 12'd1;
            r_radius <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
        end else if (i_cfg_we) begin
            case (fsp_pkg::t_cfg_idx'(i_cfg_idx))
                fsp_pkg::CFG_TARGET_COUNT:  r_tc     <= i_cfg_data[11:0];
                fsp_pkg::CFG_SPHERE_RADIUS: r_radius <= i_cfg_data[23:0];
                fsp_pkg::CFG_CENTER_X:      r_cx     <= i_cfg_data;
                fsp_pkg::CFG_CENTER_Y:      r_cy     <= i_cfg_data;
                fsp_pkg::CFG_CENTER_Z:      r_cz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lattice size and divisor.
    assign w_tc    = (r_tc > 12'(fsp_pkg::MAX_TARGETS)) ? 12'(fsp_pkg::MAX_TARGETS) : r_tc;
    assign w_lat_n = 13'(w_tc) + 13'(fsp_pkg::EXTRA_POINTS);
    assign w_div_d = w_lat_n - 13'd1;

    // Global advance: move unless the output register holds a stalled result.
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    fsp_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_valid       (i_valid),
        .i_point_index (i_point_index),
        .i_lat_n       (w_lat_n),
        .i_div_d       (w_div_d),
        .o_valid       (w_v_div),
        .o_pt          (w_pt_div)
    );

    fsp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_v_div),
        .i_pt    (w_pt_div),
        .o_valid (w_v_sqrt),
        .o_pt    (w_pt_sqrt)
    );

    fsp_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_v_sqrt),
        .i_pt    (w_pt_sqrt),
        .o_valid (w_v_trig),
        .o_pt    (w_pt_trig)
    );

    fsp_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_valid       (w_v_trig),
        .i_pt          (w_pt_trig),
        .i_radius      (r_radius),
        .i_cx          (r_cx),
        .i_cy          (r_cy),
        .i_cz          (r_cz),
        .o_valid       (o_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_index_valid (o_index_valid)
    );

`ifndef SYNTH
    // An index past the lattice gives an all-zero point.
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_index_valid) |-> (o_pos_x == 0 && o_pos_y == 0 && o_pos_z == 0))
        else $error("out-of-range transaction with non-zero coordinates");

    // A stalled result back-pressures the input side.
    a_back_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input accepted while output stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif
endmodule
`default_nettype wire
